@@ sv/console_line_editor_top_assert.svh @@
// Assertion macros for the console line editor.
// Included by cle_back, which checks its own invariants; no other dependencies.
`ifndef CONSOLE_LINE_EDITOR_TOP_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// A condition that must hold at every rising clock edge outside reset.
`define CLE_ASSERT_ALWAYS(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
        else $error("%m: invariant violated");
// A condition that must hold whenever the antecedent holds.
`define CLE_ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: implication violated");
`else
`define CLE_ASSERT_ALWAYS(lbl, ck, rn, expr)
`define CLE_ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`endif
`endif

@@ sv/cle_pkg.sv @@
// Shared constants, command codes and the queue word type of the console line editor.
// No dependencies; imported by the front, the queue, the back end and the top level.
`timescale 1ns / 1ps
package cle_pkg;

    // Line store geometry; positions run modulo twice the depth.
    localparam int BUF_DEPTH = 128;
    localparam int SLOT_W    = $clog2(BUF_DEPTH);
    localparam int POS_MOD   = 2 * BUF_DEPTH;
    localparam int POS_W     = $clog2(POS_MOD);
    localparam int CNT_W     = (POS_W > 9) ? POS_W : 9;

    // Command queue between the front and the back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Control characters.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CTRL_D = 8'h04;
    localparam logic [7:0] CH_CTRL_H = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_CTRL_P = 8'h10;
    localparam logic [7:0] CH_CTRL_U = 8'h15;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // Echo kinds on the result word.
    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_CHAR  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    // Input kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Classified commands.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_READ,
        OP_STATUS,
        OP_KILL,
        OP_ERASE,
        OP_INSERT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic       ends_line;
    } cmd_t;

endpackage

@@ sv/console_line_editor_top.sv @@
// Results pass the front stage, the command queue and the back-end output register; one word
// per cycle for characters unless a read or the result channel holds the flow. A read that
// returns a byte holds the back end in its read-wait state for the RAM's registered read port.
// Reset (asynchronous, active low) zeroes the read, commit and edit positions and
// empties the command queue; the line store is not cleared and needs no clearing pass.
// Top level of the console line editor; depends on cle_pkg, cle_front, cle_fifo, cle_back.
`timescale 1ns / 1ps
module console_line_editor_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] rx_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] echo_kind,
    output logic [7:0] echo_byte,
    output logic [7:0] erase_count,
    output logic       read_valid,
    output logic [7:0] read_byte,
    output logic       status_request
);
    import cle_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_pop;
    cmd_t queue_cmd;

    // Classifying front end.
    cle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .rx_char   (rx_char),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // Command queue.
    cle_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_en     (queue_pop),
        .pop_cmd    (queue_cmd)
    );

    // Executing back end with the line store.
    cle_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (queue_valid),
        .cmd_pop        (queue_pop),
        .cmd            (queue_cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .echo_kind      (echo_kind),
        .echo_byte      (echo_byte),
        .erase_count    (erase_count),
        .read_valid     (read_valid),
        .read_byte      (read_byte),
        .status_request (status_request)
    );

endmodule

@@ sv/cle_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the line store of the console line editor.
`timescale 1ns / 1ps
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/cle_front.sv @@
// Front end: accepts input words, classifies them into commands and stages them.
// Depends on cle_pkg for the command type and character codes.
`timescale 1ns / 1ps
module cle_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          kind,
    input  logic [7:0]    rx_char,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output cle_pkg::cmd_t cmd
);
    import cle_pkg::*;

    cmd_t       cmd_class;
    logic [7:0] mapped_ch;
    logic       stage_valid_reg;
    cmd_t       stage_cmd_reg;
    logic       accept;

    // Classify the incoming word; CR is stored and echoed as LF.
    always_comb
    begin
        mapped_ch = (rx_char == CH_CR) ? CH_LF : rx_char;
        cmd_class.ch = mapped_ch;
        cmd_class.ends_line = mapped_ch inside {CH_LF, CH_CTRL_D};
        if (kind == KIND_READ)
        begin
            cmd_class.op = OP_READ;
        end
        else
        begin
            case (rx_char)
                CH_CTRL_P:        cmd_class.op = OP_STATUS;
                CH_CTRL_U:        cmd_class.op = OP_KILL;
                CH_CTRL_H,
                CH_DEL:           cmd_class.op = OP_ERASE;
                CH_NUL:           cmd_class.op = OP_NOP;
                default:          cmd_class.op = OP_INSERT;
            endcase
        end
    end

    // One-word stage toward the queue.
    assign in_ready = !stage_valid_reg || cmd_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_cmd_reg <= cmd_class;
        end
    end

    assign cmd_valid = stage_valid_reg;
    assign cmd       = stage_cmd_reg;

endmodule

@@ sv/cle_fifo.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on cle_pkg for the command type and the queue depth.
`timescale 1ns / 1ps
module cle_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  cle_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_en,
    output cle_pkg::cmd_t pop_cmd
);
    import cle_pkg::*;

    cmd_t                q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W:0]    count_reg;
    logic                do_push;
    logic                do_pop;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (count_reg != (Q_PTR_W + 1)'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;
    assign pop_cmd    = q_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/cle_back.sv @@
// Back end: executes queued commands against the line store and the three positions.
// Depends on cle_pkg, cle_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "console_line_editor_top_assert.svh"
module cle_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  cle_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    echo_kind,
    output logic [7:0]    echo_byte,
    output logic [7:0]    erase_count,
    output logic          read_valid,
    output logic [7:0]    read_byte,
    output logic          status_request
);
    import cle_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_READ_WAIT
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  read_pos_reg, read_pos_next;
    logic [POS_W-1:0]  commit_pos_reg, commit_pos_next;
    logic [POS_W-1:0]  edit_pos_reg, edit_pos_next;
    logic              out_valid_reg;
    logic [1:0]        echo_kind_reg, echo_kind_next;
    logic [7:0]        echo_byte_reg, echo_byte_next;
    logic [7:0]        erase_count_reg, erase_count_next;
    logic              read_valid_reg, read_valid_next;
    logic [7:0]        read_byte_reg, read_byte_next;
    logic              status_reg, status_next;
    logic              load_out;
    logic              out_free;
    logic              start;
    logic [POS_W-1:0]  fill;
    logic [POS_W-1:0]  pending;
    logic              has_room;
    logic              has_committed;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [7:0]        ram_rd_data;

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        pos_inc = (p == POS_W'(POS_MOD - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] p);
        pos_dec = (p == '0) ? POS_W'(POS_MOD - 1) : p - 1'b1;
    endfunction

    // Distance from b forward to a, modulo the position range.
    function automatic logic [POS_W-1:0] pos_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        pos_diff = (a >= b) ? a - b : a + POS_W'(POS_MOD) - b;
    endfunction

    function automatic logic [SLOT_W-1:0] pos_slot(input logic [POS_W-1:0] p);
        pos_slot = (p >= POS_W'(BUF_DEPTH)) ? SLOT_W'(p - POS_W'(BUF_DEPTH))
                                            : SLOT_W'(p);
    endfunction

    // Occupancy figures shared by the command decode.
    assign fill          = pos_diff(edit_pos_reg, read_pos_reg);
    assign pending       = pos_diff(edit_pos_reg, commit_pos_reg);
    assign has_room      = (fill < POS_W'(BUF_DEPTH));
    assign has_committed = (read_pos_reg != commit_pos_reg);
    assign out_free      = !out_valid_reg || out_ready;
    assign start         = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign cmd_pop       = start;

    assign ram_wr_en = start && (cmd.op == OP_INSERT) && has_room;
    assign ram_rd_en = start && (cmd.op == OP_READ) && has_committed;

    cle_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_slot(edit_pos_reg)),
        .wr_data (cmd.ch),
        .rd_en   (ram_rd_en),
        .rd_addr (pos_slot(read_pos_reg)),
        .rd_data (ram_rd_data)
    );

    // Command execution. The uncommitted region never holds an LF, since an LF
    // commits at once, so a kill erases the whole region in one step.
    always_comb
    begin
        state_next       = state_reg;
        read_pos_next    = read_pos_reg;
        commit_pos_next  = commit_pos_reg;
        edit_pos_next    = edit_pos_reg;
        load_out         = 1'b0;
        echo_kind_next   = ECHO_NONE;
        echo_byte_next   = '0;
        erase_count_next = '0;
        read_valid_next  = 1'b0;
        read_byte_next   = '0;
        status_next      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    load_out = 1'b1;
                    case (cmd.op)
                        OP_READ:
                        begin
                            if (has_committed)
                            begin
                                load_out   = 1'b0;
                                state_next = ST_READ_WAIT;
                            end
                        end
                        OP_STATUS:
                        begin
                            status_next = 1'b1;
                        end
                        OP_KILL:
                        begin
                            if (pending != '0)
                            begin
                                edit_pos_next    = commit_pos_reg;
                                echo_kind_next   = ECHO_ERASE;
                                erase_count_next = (CNT_W'(pending) > CNT_W'(255)) ?
                                                   8'hFF : 8'(pending);
                            end
                        end
                        OP_ERASE:
                        begin
                            if (pending != '0)
                            begin
                                edit_pos_next    = pos_dec(edit_pos_reg);
                                echo_kind_next   = ECHO_ERASE;
                                erase_count_next = 8'd1;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (has_room)
                            begin
                                edit_pos_next  = pos_inc(edit_pos_reg);
                                echo_kind_next = ECHO_CHAR;
                                echo_byte_next = cmd.ch;
                                if (cmd.ends_line || (fill == POS_W'(BUF_DEPTH - 1)))
                                begin
                                    commit_pos_next = pos_inc(edit_pos_reg);
                                end
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                if (out_free)
                begin
                    load_out        = 1'b1;
                    read_valid_next = 1'b1;
                    read_byte_next  = ram_rd_data;
                    read_pos_next   = pos_inc(read_pos_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, positions and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            read_pos_reg    <= '0;
            commit_pos_reg  <= '0;
            edit_pos_reg    <= '0;
            out_valid_reg   <= 1'b0;
            echo_kind_reg   <= ECHO_NONE;
            echo_byte_reg   <= '0;
            erase_count_reg <= '0;
            read_valid_reg  <= 1'b0;
            read_byte_reg   <= '0;
            status_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_pos_reg   <= read_pos_next;
            commit_pos_reg <= commit_pos_next;
            edit_pos_reg   <= edit_pos_next;
            if (load_out)
            begin
                out_valid_reg   <= 1'b1;
                echo_kind_reg   <= echo_kind_next;
                echo_byte_reg   <= echo_byte_next;
                erase_count_reg <= erase_count_next;
                read_valid_reg  <= read_valid_next;
                read_byte_reg   <= read_byte_next;
                status_reg      <= status_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign echo_kind      = echo_kind_reg;
    assign echo_byte      = echo_byte_reg;
    assign erase_count    = erase_count_reg;
    assign read_valid     = read_valid_reg;
    assign read_byte      = read_byte_reg;
    assign status_request = status_reg;

    // The buffer never holds more than its depth of characters.
    `CLE_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill <= POS_W'(BUF_DEPTH))
    // The commit point lies between the read point and the edit point.
    `CLE_ASSERT_ALWAYS(a_commit_order, clk, rst_n, pos_diff(commit_pos_reg, read_pos_reg) <= fill)
    // A pending read only waits while a committed byte is there.
    `CLE_ASSERT_IMPLIES(a_read_wait, clk, rst_n, state_reg == ST_READ_WAIT, has_committed)
    // A result still waiting downstream is never overwritten.
    `CLE_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !load_out)

endmodule

@@ tb/console_line_editor_checker.sv @@
// Checker for the console line editor: watches both word channels, predicts each result
// and compares it field by field. Depends on cle_pkg for geometry and character codes.
`timescale 1ns / 1ps
module console_line_editor_checker
    import cle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       kind,
    input  logic [7:0] rx_char,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] echo_kind,
    input  logic [7:0] echo_byte,
    input  logic [7:0] erase_count,
    input  logic       read_valid,
    input  logic [7:0] read_byte,
    input  logic       status_request,
    output int         mismatches,
    output int         outstanding
);

    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_byte;
        logic [7:0] erase_count;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       status_request;
    } console_result_t;

    // Shadow copy of the line store and its three positions.
    logic [7:0]       line_copy [BUF_DEPTH];
    logic [POS_W-1:0] rd_pos;
    logic [POS_W-1:0] cm_pos;
    logic [POS_W-1:0] ed_pos;

    // Results predicted but not yet returned, oldest first.
    console_result_t  awaited_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Applies one input word to the shadow state and returns the result it causes.
    function automatic console_result_t edit_line(input logic k, input logic [7:0] c);
        console_result_t  r;
        logic [7:0]       ch;
        logic [POS_W-1:0] prev;
        logic [POS_W-1:0] used;
        int unsigned      erased;
        r  = '0;
        ch = c;
        if (k == KIND_READ)
        begin
            // A read pops one committed byte, if any.
            if (rd_pos != cm_pos)
            begin
                r.read_valid = 1'b1;
                r.read_byte  = line_copy[rd_pos[SLOT_W-1:0]];
                rd_pos       = rd_pos + 1'b1;
            end
        end
        else if (ch == CH_CTRL_P)
        begin
            r.status_request = 1'b1;
        end
        else if (ch == CH_CTRL_U)
        begin
            // Kill line: walk back to the commit point or a stored line feed.
            erased = 0;
            prev   = ed_pos - 1'b1;
            while (ed_pos != cm_pos && line_copy[prev[SLOT_W-1:0]] != CH_LF)
            begin
                ed_pos = prev;
                prev   = ed_pos - 1'b1;
                erased++;
            end
            if (erased != 0)
            begin
                r.echo_kind   = ECHO_ERASE;
                r.erase_count = (erased > 255) ? 8'd255 : erased[7:0];
            end
        end
        else if (ch == CH_CTRL_H || ch == CH_DEL)
        begin
            if (ed_pos != cm_pos)
            begin
                ed_pos        = ed_pos - 1'b1;
                r.echo_kind   = ECHO_ERASE;
                r.erase_count = 8'd1;
            end
        end
        else
        begin
            // Ordinary character: stored and echoed unless null or the buffer is full.
            used = ed_pos - rd_pos;
            if (ch != CH_NUL && used < BUF_DEPTH)
            begin
                if (ch == CH_CR)
                    ch = CH_LF;
                r.echo_kind = ECHO_CHAR;
                r.echo_byte = ch;
                line_copy[ed_pos[SLOT_W-1:0]] = ch;
                ed_pos = ed_pos + 1'b1;
                used   = ed_pos - rd_pos;
                if (ch == CH_LF || ch == CH_CTRL_D || used == BUF_DEPTH)
                    cm_pos = ed_pos;
            end
        end
        return r;
    endfunction

    // Predict on every accepted input word, compare on every accepted result word.
    always @(posedge clk or negedge rst_n)
    begin : watch
        console_result_t want;
        console_result_t got;
        if (!rst_n)
        begin
            rd_pos = '0;
            cm_pos = '0;
            ed_pos = '0;
            awaited_results.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                awaited_results.push_back(edit_line(kind, rx_char));
            if (out_valid && out_ready)
            begin
                got = {echo_kind, echo_byte, erase_count, read_valid, read_byte,
                       status_request};
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result word arrived with nothing expected");
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.echo_kind != want.echo_kind)
                        report_mismatch($sformatf("echo_kind got %0d want %0d",
                                                  got.echo_kind, want.echo_kind));
                    if (got.echo_byte != want.echo_byte)
                        report_mismatch($sformatf("echo_byte got %0h want %0h",
                                                  got.echo_byte, want.echo_byte));
                    if (got.erase_count != want.erase_count)
                        report_mismatch($sformatf("erase_count got %0d want %0d",
                                                  got.erase_count, want.erase_count));
                    if (got.read_valid != want.read_valid)
                        report_mismatch($sformatf("read_valid got %0d want %0d",
                                                  got.read_valid, want.read_valid));
                    if (got.read_byte != want.read_byte)
                        report_mismatch($sformatf("read_byte got %0h want %0h",
                                                  got.read_byte, want.read_byte));
                    if (got.status_request != want.status_request)
                        report_mismatch($sformatf("status_request got %0d want %0d",
                                                  got.status_request, want.status_request));
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

@@ tb/console_line_editor_top_tb.sv @@
// Testbench top for the console line editor: drives directed and random words, stalls both
// channels and gives the verdict. Depends on cle_pkg, the RTL and console_line_editor_checker.
`timescale 1ns / 1ps
module console_line_editor_top_tb;
    import cle_pkg::*;

    localparam int WORD_TARGET  = 650;
    localparam int CALM_TAIL    = 80;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       kind;
    logic [7:0] rx_char;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] echo_kind;
    logic [7:0] echo_byte;
    logic [7:0] erase_count;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       status_request;
    int         mismatches;
    int         outstanding;

    int         words_sent  = 0;
    int         cycle_count = 0;
    int         gap_pct     = 0;
    int         stall_pct   = 0;
    logic       hold_req    = 1'b0;

    console_line_editor_top dut (.*);

    console_line_editor_checker line_check (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Offers one word at a falling edge, after an optional idle burst, and waits for it to go.
    task automatic send_word(input logic k, input logic [7:0] c);
        int gap;
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            gap      = $urandom_range(1, 12);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = k;
        rx_char  = c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // Types a line with occasional edits, ends it most of the time, then reads some back.
    task automatic edit_session();
        int len;
        int reads;
        len = $urandom_range(0, 12);
        repeat (len)
        begin
            case ($urandom_range(0, 19))
                0, 1:    send_word(KIND_CHAR, $urandom_range(0, 1) ? CH_DEL : CH_CTRL_H);
                2:       send_word(KIND_CHAR, CH_CTRL_U);
                3:       send_word(KIND_CHAR, CH_CTRL_P);
                4:       send_word(KIND_CHAR, CH_NUL);
                default: send_word(KIND_CHAR, text_char());
            endcase
        end
        case ($urandom_range(0, 7))
            0:          ;
            1, 2, 3:    send_word(KIND_CHAR, CH_CR);
            4, 5:       send_word(KIND_CHAR, CH_LF);
            default:    send_word(KIND_CHAR, CH_CTRL_D);
        endcase
        reads = $urandom_range(0, len + 3);
        repeat (reads)
            send_word(KIND_READ, 8'($urandom()));
    endtask

    // Types past the buffer depth so the line commits on full and the rest is dropped,
    // then drains everything.
    task automatic fill_buffer();
        repeat (BUF_DEPTH + 3)
            send_word(KIND_CHAR, 8'($urandom_range(8'h20, 8'h7E)));
        send_word(KIND_CHAR, CH_CTRL_U);
        send_word(KIND_CHAR, CH_CTRL_H);
        repeat (BUF_DEPTH + 2)
            send_word(KIND_READ, 8'($urandom()));
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none in the calm tail.
    initial
    begin : receiver
        int   stall_len;
        logic hold_taken;
        hold_taken = 1'b0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready  = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                stall_len = $urandom_range(1, 12);
                out_ready = 1'b0;
                repeat (stall_len - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Watchdog on the cycle count.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("console_line_editor_top test failed");
        $finish;
    end

    initial
    begin
        in_valid = 1'b0;
        kind     = KIND_CHAR;
        rx_char  = CH_NUL;
        rst_n    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty read, null, edits on an empty line, status, extreme bytes,
        // erase and kill, CR mapped to LF, Ctrl-D commit, reads past the end.
        send_word(KIND_READ, 8'hFF);
        send_word(KIND_CHAR, CH_NUL);
        send_word(KIND_CHAR, CH_CTRL_H);
        send_word(KIND_CHAR, CH_CTRL_U);
        send_word(KIND_CHAR, CH_CTRL_P);
        send_word(KIND_CHAR, "a");
        send_word(KIND_CHAR, 8'hFF);
        send_word(KIND_CHAR, 8'h80);
        send_word(KIND_CHAR, 8'h01);
        send_word(KIND_CHAR, CH_DEL);
        send_word(KIND_CHAR, CH_CTRL_H);
        send_word(KIND_CHAR, "k");
        send_word(KIND_CHAR, CH_CTRL_U);
        send_word(KIND_CHAR, "x");
        send_word(KIND_CHAR, "y");
        send_word(KIND_CHAR, CH_CR);
        repeat (4)
            send_word(KIND_READ, 8'h00);
        send_word(KIND_CHAR, "q");
        send_word(KIND_CHAR, CH_CTRL_D);
        send_word(KIND_READ, 8'h00);
        send_word(KIND_READ, 8'h00);

        // Random part, opening with one full-buffer pass.
        fill_buffer();
        while (words_sent < WORD_TARGET)
        begin
            if (words_sent >= WORD_TARGET - CALM_TAIL)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end
            if (words_sent >= HOLD_AT)
                hold_req = 1'b1;
            case ($urandom_range(0, 39))
                0:
                begin
                    // A full-buffer pass only while it still fits in the word budget.
                    if (words_sent < WORD_TARGET - CALM_TAIL - 2 * BUF_DEPTH)
                    begin
                        fill_buffer();
                    end
                    else
                    begin
                        edit_session();
                    end
                end
                1, 2, 3:    repeat ($urandom_range(1, 4))
                                send_word(1'($urandom_range(0, 1)), 8'($urandom()));
                default:    edit_session();
            endcase
        end
        @(negedge clk);
        in_valid = 1'b0;

        // Wait for every predicted result, then let the pipeline settle.
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("console_line_editor_top test passed");
        else
            $display("console_line_editor_top test failed");
        $finish;
    end

endmodule
